[rtl/core/qth_pkg.sv]
// qth_pkg: shared types and constants for the tukey hinge quartile block
// no dependencies
`timescale 1ns / 1ps
package qth_pkg;
    localparam int SAMPLE_W = 32;
    localparam int RESULT_W = 33;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PASS_INIT,
        ST_MERGE_RD,
        ST_MERGE_WAIT,
        ST_MERGE_CMP,
        ST_PASS_END,
        ST_HINGE_RD,
        ST_HINGE_WAIT,
        ST_HINGE_ACC,
        ST_OUT
    } t_state;

    // request from sequencer to memory
    typedef struct packed {
        logic rd_a;
        logic rd_b;
        logic wr;
    } t_mem_ctl;
endpackage

[rtl/core/qth_ram.sv]
// qth_ram: simple dual-port sample memory, one write and two registered reads
// depends on qth_pkg
`timescale 1ns / 1ps
module qth_ram #(
    parameter int DEPTH = 2048,
    parameter int AW = 11
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic signed [31:0]    i_wdata,
    input  logic                  i_re_a,
    input  logic                  i_re_b,
    input  logic [AW-1:0]         i_raddr_a,
    input  logic [AW-1:0]         i_raddr_b,
    output logic signed [31:0]    o_rdata_a,
    output logic signed [31:0]    o_rdata_b
);
    import qth_pkg::*;
    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];

    // read data holds until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule

[rtl/core/quartile_tukey_hinges_unit.sv]
// quartile_tukey_hinges_unit: collects a set, merge sorts it in memory, emits hinges
// after the last transfer: ceil(log2 n) merge passes, the run width doubling each pass,
// then hinge reads to a valid result
// throughput: one sample per cycle while loading; no transfers during sort; the next
// set loads while a result waits in the output register
// each merge step goes through read, wait and compare/write states on the memory port
// reset: synchronous active low, clears count, overflow flag and sequencer; memory untouched
`timescale 1ns / 1ps
module quartile_tukey_hinges_unit #(
    parameter int MAX_SAMPLES = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // sample[31:0]
    input  logic         s_axis_tlast,   // last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // lower_quartile[32:0], middle_value[65:33],
                                         // upper_quartile[98:66], zero fill
    output logic         m_axis_tuser    // overflowed
);
    import qth_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);  // count width
    localparam int IW = $clog2(MAX_SAMPLES);      // index width
    localparam int AW = IW + 1;                   // bank bit on top

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_bank, n_bank;        // bank holding current sorted runs
    logic [CW-1:0] r_width, n_width;      // run width of this pass
    logic [CW-1:0] r_base, n_base;        // start of current run pair
    logic [CW-1:0] r_i, n_i;              // left run index
    logic [CW-1:0] r_j, n_j;              // right run index
    logic [CW-1:0] r_k, n_k;              // output index
    logic [1:0]    r_hsel, n_hsel;        // which hinge element is being read
    logic signed [RESULT_W-1:0] r_q1, n_q1, r_q2, n_q2, r_q3, n_q3;
    logic          r_tvalid, n_tvalid;
    // output register, frees the hinge registers for the next set
    logic [3*RESULT_W-1:0] r_out_hinges, n_out_hinges;
    logic          r_out_ovf, n_out_ovf;

    t_mem_ctl   mem;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic signed [31:0] wdata, rdata_a, rdata_b;

    // run limits, widened to avoid wrap
    logic [CW:0] mid_e, end_e;
    logic        left_ok, right_ok, take_left;

    assign mid_e = ({1'b0, r_base} + {1'b0, r_width} > {1'b0, r_count}) ?
                   {1'b0, r_count} : ({1'b0, r_base} + {1'b0, r_width});
    assign end_e = (mid_e + {1'b0, r_width} > {1'b0, r_count}) ?
                   {1'b0, r_count} : (mid_e + {1'b0, r_width});
    assign left_ok  = {1'b0, r_i} < mid_e;
    assign right_ok = {1'b0, r_j} < end_e;
    assign take_left = left_ok && (!right_ok || (rdata_a <= rdata_b));

    // hinge element indexes: two reads per hinge (odd length reads same twice)
    logic [CW-1:0] lo_len, hi_start, hi_len, h_start, h_len, h_mid, h_prev;
    assign lo_len   = CW'((({1'b0, r_count}) + 1'b1) >> 1);
    assign hi_start = r_count >> 1;
    assign hi_len   = r_count - hi_start;
    always_comb begin
        case (r_hsel)
            2'd0: begin h_start = '0;       h_len = lo_len;  end
            2'd1: begin h_start = '0;       h_len = r_count; end
            default: begin h_start = hi_start; h_len = hi_len; end
        endcase
    end
    assign h_mid  = h_start + (h_len >> 1);
    assign h_prev = h_len[0] ? h_mid : h_mid - 1'b1;

    logic s_xfer, m_xfer;
    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;

    // memory address and control selection
    always_comb begin
        mem     = '0;
        waddr   = {r_bank, r_count[IW-1:0]};
        wdata   = s_axis_tdata;
        raddr_a = {r_bank, r_i[IW-1:0]};
        raddr_b = {r_bank, r_j[IW-1:0]};
        case (r_state)
            ST_LOAD: begin
                mem.wr = s_xfer && (r_count < CW'(MAX_SAMPLES));
            end
            ST_MERGE_RD: begin
                mem.rd_a = 1'b1;
                mem.rd_b = 1'b1;
            end
            ST_MERGE_CMP: begin
                mem.wr = left_ok || right_ok;
                waddr  = {~r_bank, r_k[IW-1:0]};
                wdata  = take_left ? rdata_a : rdata_b;
            end
            ST_HINGE_RD: begin
                mem.rd_a = 1'b1;
                mem.rd_b = 1'b1;
                raddr_a  = {r_bank, h_prev[IW-1:0]};
                raddr_b  = {r_bank, h_mid[IW-1:0]};
            end
            default: ;
        endcase
    end

    qth_ram #(.DEPTH(2 ** AW), .AW(AW)) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem.wr),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re_a    (mem.rd_a),
        .i_re_b    (mem.rd_b),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:       if (s_xfer && s_axis_tlast) n_state = ST_PASS_INIT;
            ST_PASS_INIT:  n_state = (r_width >= r_count) ? ST_HINGE_RD : ST_MERGE_RD;
            ST_MERGE_RD:   n_state = ST_MERGE_WAIT;
            ST_MERGE_WAIT: n_state = ST_MERGE_CMP;
            ST_MERGE_CMP:  n_state = ST_MERGE_RD;
            ST_PASS_END:   n_state = ST_PASS_INIT;
            ST_HINGE_RD:   n_state = ST_HINGE_WAIT;
            ST_HINGE_WAIT: n_state = ST_HINGE_ACC;
            ST_HINGE_ACC:  n_state = (r_hsel == 2'd2) ? ST_OUT : ST_HINGE_RD;
            ST_OUT:        if (!r_tvalid) n_state = ST_LOAD;
            default:       n_state = ST_LOAD;
        endcase
        // run pair done: the pass ends when it reached the end of the set
        if (r_state == ST_MERGE_CMP && !(left_ok || right_ok)) begin
            n_state = (end_e == {1'b0, r_count}) ? ST_PASS_END : ST_MERGE_RD;
        end
    end

    // datapath updates
    always_comb begin
        n_count = r_count; n_ovf = r_ovf; n_bank = r_bank; n_width = r_width;
        n_base = r_base; n_i = r_i; n_j = r_j; n_k = r_k; n_hsel = r_hsel;
        n_q1 = r_q1; n_q2 = r_q2; n_q3 = r_q3;
        n_out_hinges = r_out_hinges; n_out_ovf = r_out_ovf;
        n_tvalid = r_tvalid && !m_xfer;
        case (r_state)
            ST_LOAD: begin
                n_width = CW'(1);
                n_base  = '0;
                n_hsel  = '0;
                if (s_xfer) begin
                    if (r_count < CW'(MAX_SAMPLES)) n_count = r_count + 1'b1;
                    else n_ovf = 1'b1;
                end
            end
            ST_PASS_INIT: begin
                n_base = '0;
                n_i    = '0;
                n_k    = '0;
                n_j    = (r_width > r_count) ? r_count : r_width;
            end
            ST_MERGE_CMP: begin
                if (left_ok || right_ok) begin
                    n_k = r_k + 1'b1;
                    if (take_left) n_i = r_i + 1'b1;
                    else n_j = r_j + 1'b1;
                end else begin
                    n_base = CW'(end_e);
                    n_i    = CW'(end_e);
                    n_j    = CW'((end_e + {1'b0, r_width} > {1'b0, r_count}) ?
                                 {1'b0, r_count} : end_e + {1'b0, r_width});
                end
            end
            ST_PASS_END: begin
                n_bank  = ~r_bank;
                n_width = CW'({1'b0, r_width} << 1);
            end
            ST_HINGE_ACC: begin
                n_hsel = r_hsel + 1'b1;
                case (r_hsel)
                    2'd0: n_q1 = RESULT_W'(rdata_a) + RESULT_W'(rdata_b);
                    2'd1: n_q2 = RESULT_W'(rdata_a) + RESULT_W'(rdata_b);
                    default: n_q3 = RESULT_W'(rdata_a) + RESULT_W'(rdata_b);
                endcase
            end
            ST_OUT: begin
                // move the result out once the output register is free
                if (!r_tvalid) begin
                    n_tvalid     = 1'b1;
                    n_out_hinges = {r_q3, r_q2, r_q1};
                    n_out_ovf    = r_ovf;
                    n_count      = '0;
                    n_ovf        = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_bank    <= 1'b0;
            r_tvalid  <= 1'b0;
            r_hsel    <= '0;
            r_out_ovf <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_bank    <= n_bank;
            r_tvalid  <= n_tvalid;
            r_hsel    <= n_hsel;
            r_out_ovf <= n_out_ovf;
        end
        r_width <= n_width; r_base <= n_base;
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
        r_q1 <= n_q1; r_q2 <= n_q2; r_q3 <= n_q3;
        r_out_hinges <= n_out_hinges;
    end

    // result held in the output register until taken; loading goes on meanwhile
    assign s_axis_tready = (r_state == ST_LOAD);
    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = {5'd0, r_out_hinges};
    assign m_axis_tuser  = r_out_ovf;

`ifndef NO_ASSERTIONS
    // the store never holds more than its capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SAMPLES)) else $error("sample count beyond capacity");
    // a waiting result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while pending");
    // closing a set starts the sort
    a_last_sorts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && s_axis_tlast) |=> (r_state == ST_PASS_INIT))
        else $error("last transfer did not start sort");
`endif
endmodule
